>>> sv/isometric_depth_order_sort_top_macros.svh
// Assertion macros used by the depth-order sort sequencer, idos_seq.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ISOMETRIC_DEPTH_ORDER_SORT_TOP_MACROS_SVH
`define ISOMETRIC_DEPTH_ORDER_SORT_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define IDOS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define IDOS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IDOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/idos_pkg.sv
// Package for the isometric depth-order sort: footprint type, relation codes,
// the pairwise relation and the centre key. No dependencies.
package idos_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int KEY_W       = 19;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         ex;
    logic [9:0]         ey;
  } obj_t;

  localparam int OBJ_W = $bits(obj_t);

  typedef logic [1:0] rel_t;
  localparam rel_t REL_SAME   = 2'd0;
  localparam rel_t REL_AFTER  = 2'd1;
  localparam rel_t REL_BEFORE = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
  } emit_t;

  // Relation of footprint p to footprint q; the first rule that holds wins.
  function automatic rel_t relate(obj_t p, obj_t q);
    logic signed [17:0] px, py, qx, qy, pxe, pye, qxe, qye;
    rel_t r;
    begin
      px  = {{2{p.x[15]}}, p.x};
      py  = {{2{p.y[15]}}, p.y};
      qx  = {{2{q.x[15]}}, q.x};
      qy  = {{2{q.y[15]}}, q.y};
      pxe = px + $signed({8'd0, p.ex});
      pye = py + $signed({8'd0, p.ey});
      qxe = qx + $signed({8'd0, q.ex});
      qye = qy + $signed({8'd0, q.ey});
      if (py < qye && px > qx)         r = REL_AFTER;
      else if (pxe > qx && py < qy)    r = REL_AFTER;
      else if (pye > qy && pxe <= qx)  r = REL_BEFORE;
      else if (px < qxe && py >= qye)  r = REL_BEFORE;
      else                             r = REL_SAME;
      return r;
    end
  endfunction

  // (2x + ex) - (2y + ey), never overflows 19 bits.
  function automatic logic signed [KEY_W-1:0] centre_key(obj_t p);
    logic signed [KEY_W-1:0] k;
    begin
      k = $signed({{2{p.x[15]}}, p.x, 1'b0}) + $signed({9'd0, p.ex})
        - $signed({{2{p.y[15]}}, p.y, 1'b0}) - $signed({9'd0, p.ey});
      return k;
    end
  endfunction

endpackage

>>> sv/isometric_depth_order_sort_top.sv
// Top level of the isometric depth-order sort: the sequencer plus the result register.
// Depends on idos_pkg and idos_seq.
//
//  channel | direction | words
//  in_     | input     | one footprint per word, last_in closes the set
//  out_    | output    | one arrival index per word in drawing order, last_out on the final one
//
// Loading accepts words while the sequencer is idle. After the last word, ranking reads
// every object for each object, bounded by the single read port of the object memory.
// Insertion walks the placed list and moves entries via the link and collection memories;
// read-out fetches each word and holds while the output register is full.
// Reset clears the control state only; the memories need no clearing.
// The final result waits in the output register while the next set is already being loaded.
module isometric_depth_order_sort_top
  import idos_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [9:0]         in_extent_x,
  input  logic [9:0]         in_extent_y,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_object_index,
  output logic               out_last_out
);

  emit_t            emit;
  logic             emit_ok;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_last_r, out_last_nxt;

  idos_seq u_seq (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y,
    .in_extent_x, .in_extent_y, .in_last_in, .emit, .emit_ok
  );

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (emit.valid && emit_ok) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = emit.idx;
      out_last_nxt  = emit.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_object_index = out_idx_r;
  assign out_last_out     = out_last_r;

endmodule

>>> sv/idos_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module idos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/idos_seq.sv
// Sequencer of the depth-order sort: loads objects, ranks them by centre key,
// builds the drawing order in the link memory and reads it out.
// Depends on idos_pkg, idos_ram and the assertion macro header.
`include "isometric_depth_order_sort_top_macros.svh"

module idos_seq
  import idos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [9:0]        in_extent_x,
  input  logic [9:0]        in_extent_y,
  input  logic              in_last_in,
  output emit_t             emit,
  input  logic              emit_ok
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_RS   = 5'd1,  S_RSW  = 5'd2,  S_RK  = 5'd3;
  localparam logic [4:0] S_RKWR = 5'd4,  S_ISRD = 5'd5,  S_ISW  = 5'd6,  S_IAW = 5'd7;
  localparam logic [4:0] S_WL   = 5'd8,  S_WB   = 5'd9,  S_WC   = 5'd10, S_CRD = 5'd11;
  localparam logic [4:0] S_CWR  = 5'd12, S_MRD  = 5'd13, S_MWR  = 5'd14, S_FIN = 5'd15;
  localparam logic [4:0] S_SRD  = 5'd16, S_SWR  = 5'd17, S_PUT  = 5'd18, S_LRD = 5'd19;
  localparam logic [4:0] S_LWR  = 5'd20, S_NXT  = 5'd21, S_ERD  = 5'd22, S_EWR = 5'd23;

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] MAX = CNT_W'(MAX_OBJECTS);

  logic [4:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt, s_r, s_nxt, t_r, t_nxt, rank_r, rank_nxt;
  logic [CNT_W-1:0]       len_r, len_nxt, j_r, j_nxt, fidx_r, fidx_nxt;
  logic [CNT_W-1:0]       mark_r, mark_nxt, nc_r, nc_nxt, cnt_r, cnt_nxt, i_r, i_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       a_r, a_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  obj_t                   pa_r, pa_nxt, anc_r, anc_nxt;

  logic                   obj_we, obj_re;
  logic [IDX_W-1:0]       obj_waddr, obj_raddr;
  obj_t                   obj_wdata, obj_rdata;
  logic                   lk_we, lk_re, cl_we, cl_re, so_we, so_re;
  logic [IDX_W-1:0]       lk_waddr, lk_raddr, cl_waddr, cl_raddr, so_waddr, so_raddr;
  logic [IDX_W-1:0]       lk_wdata, lk_rdata, cl_wdata, cl_rdata, so_wdata, so_rdata;

  logic                   accept;
  logic [CNT_W-1:0]       j1, i1, s1, ti, mark1i, ji, nci, ncm1i, fidx1i, inc, len_cut;
  logic signed [KEY_W-1:0] key_t;
  rel_t                   rel_ab, rel_ba;

  idos_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_OBJECTS)) u_obj (
    .clk, .we(obj_we), .waddr(obj_waddr), .wdata(obj_wdata),
    .re(obj_re), .raddr(obj_raddr), .rdata(obj_rdata)
  );
  idos_ram #(.WIDTH(IDX_W), .DEPTH(MAX_OBJECTS)) u_links (
    .clk, .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .re(lk_re), .raddr(lk_raddr), .rdata(lk_rdata)
  );
  idos_ram #(.WIDTH(IDX_W), .DEPTH(MAX_OBJECTS)) u_coll (
    .clk, .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
    .re(cl_re), .raddr(cl_raddr), .rdata(cl_rdata)
  );
  idos_ram #(.WIDTH(IDX_W), .DEPTH(MAX_OBJECTS)) u_sorted (
    .clk, .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
    .re(so_re), .raddr(so_raddr), .rdata(so_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign j1      = j_r + ONE;
  assign i1      = i_r + ONE;
  assign s1      = s_r + ONE;
  assign ti      = t_r - ONE;
  assign mark1i  = mark_r + ONE + i_r;
  assign ji      = j_r + i_r;
  assign nci     = nc_r + i_r;
  assign ncm1i   = nc_r - ONE - i_r;
  assign fidx1i  = fidx_r + ONE + i_r;
  assign inc     = i_r + nc_r + ONE;
  assign len_cut = len_r - cnt_r;
  assign key_t   = centre_key(obj_rdata);
  assign rel_ab  = relate(pa_r, obj_rdata);
  assign rel_ba  = relate(obj_rdata, anc_r);

  always_comb begin
    state_nxt = state_r;  count_nxt = count_r; n_nxt = n_r;     s_nxt = s_r;
    t_nxt     = t_r;      rank_nxt  = rank_r;  len_nxt = len_r; j_nxt = j_r;
    fidx_nxt  = fidx_r;   mark_nxt  = mark_r;  nc_nxt = nc_r;   cnt_nxt = cnt_r;
    i_nxt     = i_r;      found_nxt = found_r; a_nxt = a_r;     key_nxt = key_r;
    pa_nxt    = pa_r;     anc_nxt   = anc_r;
    obj_we = 1'b0; obj_waddr = count_r[IDX_W-1:0];
    obj_wdata = '{x: in_pos_x, y: in_pos_y, ex: in_extent_x, ey: in_extent_y};
    obj_re = 1'b0; obj_raddr = s_r[IDX_W-1:0];
    lk_we = 1'b0;  lk_waddr = len_r[IDX_W-1:0]; lk_wdata = a_r;
    lk_re = 1'b0;  lk_raddr = j_r[IDX_W-1:0];
    cl_we = 1'b0;  cl_waddr = nci[IDX_W-1:0];   cl_wdata = lk_rdata;
    cl_re = 1'b0;  cl_raddr = ncm1i[IDX_W-1:0];
    so_we = 1'b0;  so_waddr = rank_r[IDX_W-1:0]; so_wdata = s_r[IDX_W-1:0];
    so_re = 1'b0;  so_raddr = s_r[IDX_W-1:0];
    emit = '{valid: 1'b0, idx: lk_rdata, last: (i_r == n_r - ONE)};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (count_r < MAX) begin
            obj_we    = 1'b1;
            count_nxt = count_r + ONE;
          end
          if (in_last_in) begin
            n_nxt     = (count_r < MAX) ? count_r + ONE : count_r;
            s_nxt     = '0;
            state_nxt = S_RS;
          end
        end
      end
      // Rank pass: the rank of object s is the number of objects that sort ahead of it.
      S_RS: begin
        obj_re    = 1'b1;
        state_nxt = S_RSW;
      end
      S_RSW: begin
        key_nxt   = key_t;
        t_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_RK;
      end
      S_RK: begin
        obj_raddr = t_r[IDX_W-1:0];
        obj_re    = (t_r < n_r);
        if (t_r != '0) begin
          if (key_t < key_r || (key_t == key_r && ti < s_r)) begin
            rank_nxt = rank_r + ONE;
          end
        end
        t_nxt = t_r + ONE;
        if (t_r == n_r) begin
          state_nxt = S_RKWR;
        end
      end
      S_RKWR: begin
        so_we = 1'b1;
        if (s1 == n_r) begin
          s_nxt     = '0;
          len_nxt   = '0;
          state_nxt = S_ISRD;
        end else begin
          s_nxt     = s1;
          state_nxt = S_RS;
        end
      end
      S_ISRD: begin
        so_re     = 1'b1;
        state_nxt = S_ISW;
      end
      S_ISW: begin
        a_nxt     = so_rdata;
        obj_re    = 1'b1;
        obj_raddr = so_rdata;
        state_nxt = S_IAW;
      end
      S_IAW: begin
        pa_nxt    = obj_rdata;
        j_nxt     = '0;
        found_nxt = 1'b0;
        nc_nxt    = '0;
        state_nxt = (len_r == '0) ? S_FIN : S_WL;
      end
      S_WL: begin
        lk_re     = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        obj_re    = 1'b1;
        obj_raddr = lk_rdata;
        state_nxt = S_WC;
      end
      S_WC: begin
        state_nxt = (j1 < len_r) ? S_WL : S_FIN;
        j_nxt     = j1;
        if (!found_r) begin
          if (rel_ab == REL_BEFORE) begin
            found_nxt = 1'b1;
            fidx_nxt  = j_r;
            mark_nxt  = j_r;
            anc_nxt   = obj_rdata;
          end
        end else if (rel_ba == REL_AFTER) begin
          mark_nxt = j_r;
        end else if (rel_ab == REL_AFTER && (j_r - mark_r) > ONE) begin
          // Objects strictly between the mark and this one move to the collection.
          cnt_nxt   = j_r - mark_r - ONE;
          i_nxt     = '0;
          j_nxt     = j_r;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        lk_re     = 1'b1;
        lk_raddr  = mark1i[IDX_W-1:0];
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cl_we = 1'b1;
        if (i1 == cnt_r) begin
          nc_nxt    = nc_r + cnt_r;
          i_nxt     = '0;
          state_nxt = S_MRD;
        end else begin
          i_nxt     = i1;
          state_nxt = S_CRD;
        end
      end
      // Close the gap: the tail from j onwards slides down to just after the mark.
      S_MRD: begin
        lk_re     = 1'b1;
        lk_raddr  = ji[IDX_W-1:0];
        state_nxt = S_MWR;
      end
      S_MWR: begin
        lk_we    = 1'b1;
        lk_waddr = mark1i[IDX_W-1:0];
        lk_wdata = lk_rdata;
        if (ji + ONE == len_r) begin
          len_nxt   = len_cut;
          j_nxt     = mark_r + CNT_W'(2);
          state_nxt = (mark_r + CNT_W'(2) < len_cut) ? S_WL : S_FIN;
        end else begin
          i_nxt     = i1;
          state_nxt = S_MRD;
        end
      end
      S_FIN: begin
        if (!found_r) begin
          lk_we     = 1'b1;
          len_nxt   = len_r + ONE;
          state_nxt = S_NXT;
        end else begin
          i_nxt     = len_r - ONE;
          state_nxt = S_SRD;
        end
      end
      // Open room for the new object and the collection, top entry first.
      S_SRD: begin
        lk_re     = 1'b1;
        lk_raddr  = i_r[IDX_W-1:0];
        state_nxt = S_SWR;
      end
      S_SWR: begin
        lk_we    = 1'b1;
        lk_waddr = inc[IDX_W-1:0];
        lk_wdata = lk_rdata;
        if (i_r == fidx_r) begin
          state_nxt = S_PUT;
        end else begin
          i_nxt     = i_r - ONE;
          state_nxt = S_SRD;
        end
      end
      S_PUT: begin
        lk_we    = 1'b1;
        lk_waddr = fidx_r[IDX_W-1:0];
        i_nxt    = '0;
        if (nc_r == '0) begin
          len_nxt   = len_r + ONE;
          state_nxt = S_NXT;
        end else begin
          state_nxt = S_LRD;
        end
      end
      // The collection goes back in reverse order.
      S_LRD: begin
        cl_re     = 1'b1;
        state_nxt = S_LWR;
      end
      S_LWR: begin
        lk_we    = 1'b1;
        lk_waddr = fidx1i[IDX_W-1:0];
        lk_wdata = cl_rdata;
        if (i1 == nc_r) begin
          len_nxt   = len_r + ONE + nc_r;
          state_nxt = S_NXT;
        end else begin
          i_nxt     = i1;
          state_nxt = S_LRD;
        end
      end
      S_NXT: begin
        if (s1 == n_r) begin
          i_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          s_nxt     = s1;
          state_nxt = S_ISRD;
        end
      end
      S_ERD: begin
        lk_re     = 1'b1;
        lk_raddr  = i_r[IDX_W-1:0];
        state_nxt = S_EWR;
      end
      S_EWR: begin
        emit.valid = 1'b1;
        if (emit_ok) begin
          if (i_r == n_r - ONE) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i1;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;       s_r <= s_nxt;       t_r <= t_nxt;         rank_r <= rank_nxt;
    len_r <= len_nxt;   j_r <= j_nxt;       fidx_r <= fidx_nxt;   mark_r <= mark_nxt;
    nc_r <= nc_nxt;     cnt_r <= cnt_nxt;   i_r <= i_nxt;         found_r <= found_nxt;
    a_r <= a_nxt;       key_r <= key_nxt;   pa_r <= pa_nxt;       anc_r <= anc_nxt;
  end

  `IDOS_ASSERT_ALWAYS(a_count_bound, count_r <= MAX, "object count beyond capacity")
  `IDOS_ASSERT_NEXT(a_last_starts, accept && in_last_in, state_r == S_RS, "last word did not start ranking")
  `IDOS_ASSERT_IMPL(a_mark_order, state_r == S_WC && found_r, fidx_r <= mark_r && mark_r < j_r, "mark outside anchor and walk position")
  `IDOS_ASSERT_IMPL(a_coll_room, state_r == S_CWR, nci < n_r && len_r <= n_r, "collection overruns the object set")

endmodule

>>> tb/sv/tb.sv
// Testbench for isometric_depth_order_sort_top: directed and random footprint sets
// are driven in, the expected drawing order is predicted in the bench and compared
// word by word. Depends on idos_pkg and the RTL of the depth-order sort.
module tb;
  import idos_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         ex;
    logic [9:0]         ey;
    logic               last;
  } fp_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } order_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [9:0]         in_extent_x;
  logic [9:0]         in_extent_y;
  logic               in_last_in;
  logic               out_valid;
  logic               out_ready;
  logic [IDX_W-1:0]   out_object_index;
  logic               out_last_out;

  fp_word_t    pending_q[$];
  order_word_t order_q[$];
  int          n_errors;
  int          rx_hold;
  int          tx_gap;
  int          rx_gap;

  // Predictor state: the objects of the open set.
  int sx[MAX_OBJECTS];
  int sy[MAX_OBJECTS];
  int sex[MAX_OBJECTS];
  int sey[MAX_OBJECTS];
  int set_count;

  isometric_depth_order_sort_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_extent_x(in_extent_x), .in_extent_y(in_extent_y), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_object_index(out_object_index), .out_last_out(out_last_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rel_t footprint_rel(int p, int q);
    if (sy[p] < sy[q] + sey[q] && sx[p] > sx[q]) return REL_AFTER;
    if (sx[p] + sex[p] > sx[q] && sy[p] < sy[q]) return REL_AFTER;
    if (sy[p] + sey[p] > sy[q] && sx[p] + sex[p] <= sx[q]) return REL_BEFORE;
    if (sx[p] < sx[q] + sex[q] && sy[p] >= sy[q] + sey[q]) return REL_BEFORE;
    return REL_SAME;
  endfunction

  function automatic int depth_key(int p);
    return (2 * sx[p] + sex[p]) - (2 * sy[p] + sey[p]);
  endfunction

  task automatic queue_word(fp_word_t f);
    pending_q.insert(pending_q.size(), f);
  endtask

  // Computes the drawing order of the open set and queues one word per object.
  task automatic predict_draw_order();
    int ranked[MAX_OBJECTS];
    int draw[MAX_OBJECTS];
    int taken[MAX_OBJECTS];
    int len, k, s, a, found, mark, nc, j, cnt, t, anchor;
    order_word_t w;
    len = 0;
    for (s = 0; s < set_count; s++) begin
      k = s;
      while (k > 0 && depth_key(ranked[k-1]) > depth_key(s)) begin
        ranked[k] = ranked[k-1];
        k--;
      end
      ranked[k] = s;
    end
    for (s = 0; s < set_count; s++) begin
      a = ranked[s];
      found = -1; mark = 0; nc = 0; j = 0; anchor = 0;
      while (j < len) begin
        if (found < 0) begin
          if (footprint_rel(a, draw[j]) == REL_BEFORE) begin
            found = j; mark = j; anchor = draw[j];
          end
        end else if (footprint_rel(draw[j], anchor) == REL_AFTER) begin
          mark = j;
        end else if (footprint_rel(a, draw[j]) == REL_AFTER) begin
          cnt = j - mark - 1;
          if (cnt > 0) begin
            for (t = 0; t < cnt; t++) taken[nc+t] = draw[mark+1+t];
            nc += cnt;
            for (t = 0; t < len - j; t++) draw[mark+1+t] = draw[j+t];
            len -= cnt;
            j = mark + 1;
          end
        end
        j++;
      end
      if (found < 0) begin
        draw[len] = a;
        len++;
      end else begin
        for (t = len - 1; t >= found; t--) draw[t+1+nc] = draw[t];
        draw[found] = a;
        for (t = 0; t < nc; t++) draw[found+1+t] = taken[nc-1-t];
        len += 1 + nc;
      end
    end
    for (k = 0; k < set_count; k++) begin
      w.idx  = draw[k][IDX_W-1:0];
      w.last = (k == set_count - 1);
      order_q.insert(order_q.size(), w);
    end
    set_count = 0;
  endtask

  task automatic accept_footprint(fp_word_t f);
    if (set_count < MAX_OBJECTS) begin
      sx[set_count]  = f.x;
      sy[set_count]  = f.y;
      sex[set_count] = f.ex;
      sey[set_count] = f.ey;
      set_count++;
    end
    if (f.last) predict_draw_order();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // Driver: one word at a time from the pending queue, with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (in_valid && in_ready) begin
      accept_footprint({in_pos_x, in_pos_y, in_extent_x, in_extent_y, in_last_in});
      in_valid <= 1'b0;
      tx_gap   <= $urandom_range(0, 8);
    end else if (!in_valid) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_q.size() > 0) begin
        if (pending_q[0] === 'x) begin
          // A marker word: pause until every expected word has arrived.
          if (order_q.size() == 0) void'(pending_q.pop_front());
        end else begin
          in_pos_x    <= pending_q[0].x;
          in_pos_y    <= pending_q[0].y;
          in_extent_x <= pending_q[0].ex;
          in_extent_y <= pending_q[0].ey;
          in_last_in  <= pending_q[0].last;
          in_valid    <= 1'b1;
          void'(pending_q.pop_front());
        end
      end
    end
  end

  // Monitor: checks each accepted word and draws the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (order_q.size() == 0) begin
          report_mismatch("unexpected word index", out_object_index, -1);
        end else begin
          if (out_object_index !== order_q[0].idx)
            report_mismatch("object_index", out_object_index, order_q[0].idx);
          if (out_last_out !== order_q[0].last)
            report_mismatch("last_out", out_last_out, order_q[0].last);
          void'(order_q.pop_front());
        end
      end
      if (rx_hold > 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        rx_gap    <= $urandom_range(0, 8);
        out_ready <= ($urandom_range(0, 3) == 0);
      end else if (rx_gap > 0) begin
        rx_gap    <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic fp_word_t rand_fp(bit last, int spread);
    fp_word_t f;
    if (spread == 0) begin
      f.x  = 16'($urandom);
      f.y  = 16'($urandom);
      f.ex = 10'($urandom);
      f.ey = 10'($urandom);
    end else begin
      f.x  = 16'($signed($urandom_range(0, 2 * spread)) - spread);
      f.y  = 16'($signed($urandom_range(0, 2 * spread)) - spread);
      f.ex = 10'($urandom_range(0, spread));
      f.ey = 10'($urandom_range(0, spread));
    end
    f.last = last;
    return f;
  endfunction

  function automatic fp_word_t mk(int x, int y, int ex, int ey, bit last);
    fp_word_t f;
    f.x = 16'(x); f.y = 16'(y); f.ex = 10'(ex); f.ey = 10'(ey); f.last = last;
    return f;
  endfunction

  task automatic add_set(int n, int spread);
    for (int i = 0; i < n; i++) queue_word(rand_fp(i == n - 1, spread));
  endtask

  initial begin
    fp_word_t pause_mark;
    int n;
    pause_mark = 'x;
    n_errors  = 0;
    set_count = 0;
    rx_hold   = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_extent_x = '0;
    in_extent_y = '0;
    in_last_in  = 1'b0;
    out_ready   = 1'b0;

    // Directed: single object, field extremes, touching and overlapping boxes, equal keys.
    queue_word(mk(0, 0, 0, 0, 1));
    queue_word(mk(-32768, -32768, 1023, 1023, 0));
    queue_word(mk(32767, 32767, 1023, 1023, 0));
    queue_word(mk(32767, -32768, 0, 0, 0));
    queue_word(mk(-32768, 32767, 1023, 0, 1));
    queue_word(mk(0, 0, 10, 10, 0));
    queue_word(mk(10, 0, 10, 10, 0));
    queue_word(mk(0, 10, 10, 10, 0));
    queue_word(mk(5, 5, 10, 10, 0));
    queue_word(mk(2, 2, 4, 4, 0));
    queue_word(mk(20, 20, 0, 0, 1));
    queue_word(mk(0, 0, 4, 4, 0));
    queue_word(mk(1, 1, 2, 2, 0));
    queue_word(mk(-1, -1, 6, 6, 1));
    queue_word(pause_mark);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Random sets, mostly small with dense overlap so the moving rules get exercised.
    while (pending_q.size() < 205) begin
      n = $urandom_range(1, 8);
      add_set(n, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 40));
    end
    queue_word(pause_mark);
    // Full store, then overflow words that are dropped, closed by the last word.
    add_set(64, 60);
    pending_q[pending_q.size()-1].last = 1'b0;
    for (int i = 0; i < 4; i++) queue_word(rand_fp(i == 3, 0));
    add_set(3, 10);

    // Long receiver stall during read-out while the sender keeps offering words.
    wait (pending_q.size() < 60);
    wait (out_valid);
    @(posedge clk);
    rx_hold <= 300;
    while (pending_q.size() > 0) @(posedge clk);
    for (int i = 0; i < 10; i++) add_set($urandom_range(1, 6), $urandom_range(3, 30));
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (order_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && order_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/idos_pkg.sv
sv/idos_ram.sv
sv/idos_seq.sv
sv/isometric_depth_order_sort_top.sv
tb/sv/tb.sv
